@@ design/xmt_pkg.sv @@
// types and constants shared by the xor mask mex trie
`default_nettype none

package xmt_pkg;

    localparam int VALUE_W = 16;
    localparam int MEX_W   = 17;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_INS_WALK,
        S_Q_ROOT,
        S_Q_WALK,
        S_Q_DONE
    } t_state;

endpackage

`default_nettype wire

@@ design/xmt_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module xmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/xor_mask_mex_trie.sv @@
// Set of distinct KEY_BITS-bit keys held as a binary count tree in one RAM of
// 2^(KEY_BITS+1) entries (node 1 is the root, children 2n and 2n+1), with a
// running XOR mask. An insert item reads the key's leaf, and if it is absent
// walks root to leaf incrementing one node per cycle; if the key is already
// present it ends after the leaf read. A query item folds its value into the
// mask and descends one level per cycle, reading only the preferred child and
// deriving its sibling's count from the parent; it stops at the root when the
// set is empty or full, or early when an empty subtree is reached, and its
// finished result waits for the previous result to leave the output register.
// The single RAM read port sets the pace of both walks.
// Items are handled one at a time; a finished result sits in an output register
// so the next item can be accepted while it waits. After reset a clearing pass
// writes zero to all 2^(KEY_BITS+1) entries, one per cycle, and no item is
// accepted until it ends. Inserts give no result.
`default_nettype none

module xor_mask_mex_trie
    import xmt_pkg::*;
#(
    parameter int KEY_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [MEX_W-1:0]   o_mex
);

    localparam int AW = KEY_BITS + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [AW-1:0] ONE = AW'(1);
    localparam logic [AW-1:0] HALF_TOP = ONE << (KEY_BITS - 1);
    localparam logic [AW-1:0] FULL = ONE << KEY_BITS;

    t_state r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [KEY_BITS-1:0] r_mask, n_mask;
    logic [KEY_BITS-1:0] r_bits, n_bits;
    logic [AW-1:0]       r_node, n_node;
    logic [AW-1:0]       r_parent, n_parent;
    logic [AW-1:0]       r_half, n_half;
    logic [AW-1:0]       r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [MEX_W-1:0]    r_mex, n_mex;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [AW-1:0]       ram_rdata;

    logic [KEY_BITS+VALUE_W-1:0] val_ext;
    logic [KEY_BITS-1:0]         key_in;
    logic [AW+MEX_W-1:0]         res_ext;
    logic [AW-1:0]               pref;
    logic [AW-1:0]               child;
    logic [AW-1:0]               child_cnt;
    logic                        pref_full;
    logic [KEY_BITS-1:0]         bits_sh;
    logic                        accept;

    assign val_ext   = {{KEY_BITS{1'b0}}, i_value};
    assign key_in    = val_ext[KEY_BITS-1:0];
    assign res_ext   = {{MEX_W{1'b0}}, r_res};
    assign accept    = i_valid && (r_state == S_IDLE);
    assign bits_sh   = r_bits << 1;
    assign pref      = {r_node[AW-2:0], r_bits[KEY_BITS-1]};
    assign pref_full = ram_rdata >= r_half;
    assign child     = pref_full ? {pref[AW-1:1], ~pref[0]} : pref;
    assign child_cnt = pref_full ? (r_parent - ram_rdata) : ram_rdata;

    xmt_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits   <= n_bits;
        r_node   <= n_node;
        r_parent <= n_parent;
        r_half   <= n_half;
        r_res    <= n_res;
        r_mex    <= n_mex;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_mask      = r_mask;
        n_bits      = r_bits;
        n_node      = r_node;
        n_parent    = r_parent;
        n_half      = r_half;
        n_res       = r_res;
        n_mex       = r_mex;
        n_out_valid = r_out_valid && i_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = ram_rdata + ONE;
        ram_raddr   = ONE;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + ONE;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_node = ONE;
                    if (i_command) begin
                        n_mask    = r_mask ^ key_in;
                        n_bits    = r_mask ^ key_in;
                        ram_raddr = ONE;
                        n_state   = S_Q_ROOT;
                    end else begin
                        n_bits    = key_in;
                        ram_raddr = {1'b1, key_in};
                        n_state   = S_INS_CHK;
                    end
                end
            end
            S_INS_CHK: begin
                if (ram_rdata != '0) begin
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = ONE;
                    n_node    = ONE;
                    n_state   = S_INS_WALK;
                end
            end
            S_INS_WALK: begin
                // bump the node read last cycle, fetch the next one down
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = ram_rdata + ONE;
                ram_raddr = pref;
                if (r_node[AW-1]) begin
                    n_state = S_IDLE;
                end else begin
                    n_node = pref;
                    n_bits = bits_sh;
                end
            end
            S_Q_ROOT: begin
                n_half   = HALF_TOP;
                n_parent = ram_rdata;
                ram_raddr = pref;
                if (ram_rdata[AW-1]) begin
                    n_res   = FULL;
                    n_state = S_Q_DONE;
                end else if (ram_rdata == '0) begin
                    n_res   = '0;
                    n_state = S_Q_DONE;
                end else begin
                    n_res   = '0;
                    n_state = S_Q_WALK;
                end
            end
            S_Q_WALK: begin
                // sibling count comes from parent minus the full preferred child
                if (pref_full) begin
                    n_res = r_res | r_half;
                end
                n_node    = child;
                n_parent  = child_cnt;
                n_half    = r_half >> 1;
                n_bits    = bits_sh;
                ram_raddr = {child[AW-2:0], bits_sh[KEY_BITS-1]};
                if (child[AW-1] || child_cnt == '0) begin
                    n_state = S_Q_DONE;
                end
            end
            S_Q_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_mex       = res_ext[MEX_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_mex   = r_mex;

`ifndef ASSERT_OFF
    a_child_le_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_WALK |-> ram_rdata <= r_parent)
        else $error("child count exceeds parent count");

    a_parent_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_WALK |-> r_parent != '0)
        else $error("descent entered an empty subtree");

    a_walk_not_past_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_WALK |-> !r_node[AW-1])
        else $error("query descent below leaf level");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_Q_DONE)
        else $error("result item raised outside query completion");

    a_insert_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_WALK && $past(r_state) == S_INS_CHK |-> r_node == ONE)
        else $error("insert walk did not start at the root");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for xor_mask_mex_trie: random insert/query items checked against a count tree predictor
`timescale 1ns / 100ps

module tb
    import xmt_pkg::*;
();

    localparam int KEY_BITS  = 16;
    localparam int NODES     = 1 << (KEY_BITS + 1);
    localparam int ALL_KEYS  = 1 << KEY_BITS;
    localparam int NUM_ITEMS = 1200;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_WAIT = 4 * (KEY_BITS + 3);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] val;
    } t_item;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               i_command = 1'b0;
    logic [VALUE_W-1:0] i_value   = '0;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [MEX_W-1:0]   o_mex;

    xor_mask_mex_trie #(
        .KEY_BITS(KEY_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_command(i_command),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_mex    (o_mex)
    );

    always #5 i_clk = ~i_clk;

    t_item            item_q[$];
    logic [MEX_W-1:0] mex_q[$];
    bit   [16:0]      subtree_cnt[NODES];
    bit   [KEY_BITS-1:0] mask_acc = '0;

    int   items_taken  = 0;
    int   errors       = 0;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic tx_pause     = 1'b0;
    logic hold_go      = 1'b0;
    int   hold_cnt     = 0;
    logic hold_on;
    t_item nxt;

    assign hold_on = hold_go && (hold_cnt < HOLD_LEN);

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 200)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic void trie_insert(input logic [KEY_BITS-1:0] key);
        int node;
        node = 1;
        if (subtree_cnt[ALL_KEYS | key] != 0)
            return;
        subtree_cnt[1]++;
        for (int p = KEY_BITS; p >= 1; p--) begin
            node = (node << 1) | key[p-1];
            subtree_cnt[node]++;
        end
    endfunction

    function automatic logic [MEX_W-1:0] trie_query_mex(input logic [KEY_BITS-1:0] mask);
        int node;
        int child;
        int half;
        int res;
        node = 1;
        res  = 0;
        if (subtree_cnt[1] >= ALL_KEYS)
            return MEX_W'(ALL_KEYS);
        for (int p = KEY_BITS; p >= 1; p--) begin
            half  = 1 << (p - 1);
            child = (node << 1) | mask[p-1];
            if (subtree_cnt[child] >= half) begin
                res   = res | half;
                child = (node << 1) | !mask[p-1];
            end
            if (subtree_cnt[child] == 0)
                break;
            node = child;
        end
        return MEX_W'(res);
    endfunction

    function automatic void apply_item(input logic cmd, input logic [VALUE_W-1:0] val);
        if (cmd == CMD_QUERY) begin
            mask_acc = mask_acc ^ val[KEY_BITS-1:0];
            mex_q.push_back(trie_query_mex(mask_acc));
        end else begin
            trie_insert(val[KEY_BITS-1:0]);
        end
    endfunction

    function automatic void push_insert(input logic [KEY_BITS-1:0] key);
        t_item it;
        it.cmd = CMD_INSERT;
        it.val = VALUE_W'(key);
        item_q.push_back(it);
    endfunction

    // queues a query that moves the running mask to target
    function automatic void push_query(inout logic [KEY_BITS-1:0] cur_mask,
                                       input logic [KEY_BITS-1:0] target);
        t_item it;
        it.cmd   = CMD_QUERY;
        it.val   = VALUE_W'(cur_mask ^ target);
        cur_mask = target;
        item_q.push_back(it);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                items_taken <= items_taken + 1;
                apply_item(i_command, i_value);
            end
            if (!i_valid || !o_stall) begin
                if (item_q.size() != 0 && !tx_pause &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = item_q.pop_front();
                    i_valid   <= 1'b1;
                    i_command <= nxt.cmd;
                    i_value   <= nxt.val;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_on || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (hold_on)
            hold_cnt <= hold_cnt + 1;
    end

    // monitor
    always @(posedge i_clk) begin
        logic [MEX_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mex_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result mex=%0d", o_mex));
            end else begin
                want = mex_q.pop_front();
                if (o_mex !== want)
                    report_mismatch($sformatf("mex got %0d expected %0d", o_mex, want));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL xor_mask_mex_trie");
        $finish;
    end

    initial begin
        logic [KEY_BITS-1:0] gen_mask;
        logic [KEY_BITS-1:0] bases[4];
        int                  fill_next[4];
        int                  sel;
        int                  len;
        int                  roll;
        int                  tx_pcts[8];
        int                  rx_pcts[8];

        gen_mask = '0;
        tx_pcts  = '{0, 75, 0, 28, 0, 75, 0, 28};
        rx_pcts  = '{0, 0, 75, 28, 0, 0, 75, 28};

        // empty set, single key, duplicate, both extremes, small contiguous set
        push_query(gen_mask, 16'h0000);
        push_insert(16'h0000);
        push_query(gen_mask, 16'h0000);
        push_insert(16'h0000);
        push_insert(16'hFFFF);
        push_query(gen_mask, 16'hFFFF);
        push_insert(16'h0001);
        push_insert(16'h0002);
        push_insert(16'h0003);
        push_insert(16'h0003);
        push_query(gen_mask, 16'h0000);
        push_query(gen_mask, 16'h0003);
        push_query(gen_mask, 16'hFFFC);
        push_insert(16'h8000);
        push_insert(16'h7FFF);
        push_query(gen_mask, 16'h8000);
        push_query(gen_mask, 16'h7FFF);
        push_query(gen_mask, 16'h0000);

        bases[0] = '0;
        for (int b = 1; b < 4; b++)
            bases[b] = KEY_BITS'($urandom_range(0, ALL_KEYS - 1));
        for (int b = 0; b < 4; b++)
            fill_next[b] = (b == 0) ? 4 : 0;

        while (item_q.size() < NUM_ITEMS) begin
            roll = $urandom_range(0, 99);
            sel  = $urandom_range(0, 3);
            if (roll < 25) begin
                // contiguous run of keys around one base, then aimed queries
                len = $urandom_range(1, 40);
                for (int j = 0; j < len; j++)
                    push_insert(bases[sel] ^ KEY_BITS'(fill_next[sel] + j));
                fill_next[sel] = fill_next[sel] + len;
                for (int j = $urandom_range(1, 4); j > 0; j--)
                    push_query(gen_mask, bases[sel] ^ KEY_BITS'($urandom_range(0, 31)));
            end else if (roll < 38) begin
                push_insert(KEY_BITS'($urandom_range(0, ALL_KEYS - 1)));
            end else if (roll < 48) begin
                push_insert(bases[sel] ^ KEY_BITS'($urandom_range(0, fill_next[sel])));
            end else if (roll < 85) begin
                push_query(gen_mask, bases[sel] ^ KEY_BITS'($urandom_range(0, 63)));
            end else begin
                push_query(gen_mask, KEY_BITS'($urandom_range(0, ALL_KEYS - 1)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 8; k++) begin
            if (k == 4) begin
                @(posedge i_clk);
                tx_pause <= 1'b1;
                while (i_valid || mex_q.size() != 0)
                    @(posedge i_clk);
                tx_pause <= 1'b0;
            end
            @(posedge i_clk);
            tx_idle_pct  <= tx_pcts[k];
            rx_stall_pct <= rx_pcts[k];
            if (k == 4)
                hold_go <= 1'b1;
            while (items_taken < (k + 1) * (NUM_ITEMS / 8))
                @(posedge i_clk);
        end

        while (item_q.size() != 0 || i_valid || mex_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (errors == 0)
            $display("PASS xor_mask_mex_trie");
        else
            $display("FAIL xor_mask_mex_trie");
        $finish;
    end

endmodule
